FILE: src/pmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared constants, codes and types of the prescaled match timer bank.
// ----------------------------------------------------------------------------
package pmt_pkg;

	localparam int CNT_W     = 32;  // count, prescale and match width
	localparam int TIMER_NUM = 2;   // timers in the bank

	localparam int WORD_W    = 32;  // bus data width
	localparam int IDX_W     = 3;
	localparam int OP_W      = 2;

	// input stream: tuser = {register_index, timer_select, operation}
	localparam int IN_USER_W  = OP_W + 1 + IDX_W;
	localparam int IN_DATA_W  = ((WORD_W + 7) / 8) * 8;
	// output stream: tdata = {pad, irq_timer1, irq_timer0, read_data}
	localparam int OUT_BITS   = WORD_W + 2;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_FLAG   = 3'd0;
	localparam logic [IDX_W-1:0] REG_CTRL   = 3'd1;
	localparam logic [IDX_W-1:0] REG_COUNT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRESC  = 3'd3;
	localparam logic [IDX_W-1:0] REG_PCOUNT = 3'd4;
	localparam logic [IDX_W-1:0] REG_MATCH  = 3'd5;
	localparam logic [IDX_W-1:0] REG_MCTRL  = 3'd6;

	// bit positions
	localparam int CTRL_EN   = 0;
	localparam int CTRL_HOLD = 1;
	localparam int MC_INT    = 0;
	localparam int MC_RST    = 1;
	localparam int MC_STOP   = 2;
	localparam int MC_W      = 3;

	// one request as seen by every timer
	typedef struct packed {
		logic              go;     // request retires this cycle
		logic              tick;
		logic              rd;
		logic              wr;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] wdata;
	} pmt_req_t;

	function automatic logic [CNT_W-1:0] word_to_cnt(input logic [WORD_W-1:0] w);
		logic [CNT_W+WORD_W-1:0] ext;
		ext = {{CNT_W{1'b0}}, w};
		return ext[CNT_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] cnt_to_word(input logic [CNT_W-1:0] v);
		logic [CNT_W+WORD_W-1:0] ext;
		ext = {{WORD_W{1'b0}}, v};
		return ext[WORD_W-1:0];
	endfunction

endpackage

FILE: src/prescaled_match_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prescaled_match_timer
// Bank of match-compare timers with prescalers behind a request stream.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ stream is a clock tick, a register read or a
//   register write (s_tuser). A tick advances every timer; reads and writes
//   address one timer and one register. Every request yields exactly one
//   result on the m_ stream: the read value (zero for ticks and writes) and
//   both interrupt flags as they stand after the request.
//   Pipeline: two register stages (input register, then result register);
//   m_tvalid rises once the request has moved from the input register into
//   the result register. Throughput: one request per cycle while m_tready
//   is high; the timer state is updated as a request moves into the result
//   register.
//   Reset clears all timer registers and empties both stages.
//   When m_tready is low the result holds; one more request is taken into
//   the input register, then s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module prescaled_match_timer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pmt_pkg::IN_DATA_W-1:0]      s_tdata,   // write_data
	input  logic [pmt_pkg::IN_USER_W-1:0]      s_tuser,   // operation, timer_select, register_index
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pmt_pkg::OUT_DATA_W-1:0]     m_tdata    // read_data, irq_timer0, irq_timer1, pad
);
	import pmt_pkg::*;

	// input register
	logic              vld_s1;
	logic [OP_W-1:0]   op_s1;
	logic              sel_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [WORD_W-1:0] wdata_s1;

	// result register
	logic              vld_s2;
	logic [WORD_W-1:0] rdata_s2;
	logic              irq0_s2, irq1_s2;

	logic              advance, s_take;
	pmt_req_t          req;
	logic [WORD_W-1:0] rd_t [TIMER_NUM];
	logic [TIMER_NUM-1:0] flag_nx;
	logic [WORD_W-1:0] rd_all;
	logic              irq1_nx;

	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign s_take   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			op_s1    <= s_tuser[OP_W-1:0];
			sel_s1   <= s_tuser[OP_W];
			idx_s1   <= s_tuser[IN_USER_W-1:OP_W+1];
			wdata_s1 <= s_tdata[WORD_W-1:0];
		end
	end

	assign req.go    = advance;
	assign req.tick  = op_s1 == OP_TICK;
	assign req.rd    = op_s1 == OP_READ;
	assign req.wr    = op_s1 == OP_WRITE;
	assign req.idx   = idx_s1;
	assign req.wdata = wdata_s1;

	for (genvar i = 0; i < TIMER_NUM; i++) begin : g_tmr
		pmt_timer u_tmr (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req),
			.hit     (int'(sel_s1) == i),
			.rdata   (rd_t[i]),
			.flag_nx (flag_nx[i])
		);
	end

	always_comb begin
		rd_all = '0;
		for (int i = 0; i < TIMER_NUM; i++)
			rd_all = rd_all | rd_t[i];
	end

	if (TIMER_NUM > 1) begin : g_irq1
		assign irq1_nx = flag_nx[1];
	end else begin : g_no_irq1
		assign irq1_nx = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (!vld_s2 || m_tready)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_s2 <= rd_all;
			irq0_s2  <= flag_nx[0];
			irq1_s2  <= irq1_nx;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, irq1_s2, irq0_s2, rdata_s2};

endmodule

FILE: src/pmt_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_timer
// One match timer: register file, prescaler, count and match actions.
// ----------------------------------------------------------------------------
module pmt_timer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pmt_pkg::pmt_req_t      req,
	input  logic                   hit,        // register access targets this timer
	output logic [pmt_pkg::WORD_W-1:0] rdata,  // zero unless a read hits
	output logic                   flag_nx     // flag after this request
);
	import pmt_pkg::*;

	logic             en_q, hold_q, flag_q;
	logic [CNT_W-1:0] cnt_q, pv_q, pc_q, mv_q;
	logic [MC_W-1:0]  mc_q;

	logic             en_d, hold_d, flag_d;
	logic [CNT_W-1:0] cnt_d, pv_d, pc_d, mv_d, cnt_adv, wfit;
	logic [MC_W-1:0]  mc_d;

	assign wfit = word_to_cnt(req.wdata);

	always_comb begin
		en_d    = en_q;
		hold_d  = hold_q;
		flag_d  = flag_q;
		cnt_d   = cnt_q;
		pv_d    = pv_q;
		pc_d    = pc_q;
		mv_d    = mv_q;
		mc_d    = mc_q;
		cnt_adv = (mc_q[MC_RST] && cnt_q == mv_q) ? '0 : cnt_q + CNT_W'(1);
		if (req.tick) begin
			if (hold_q) begin
				cnt_d = '0;
				pc_d  = '0;
			end else if (en_q) begin
				if (pc_q != pv_q) begin
					pc_d = pc_q + CNT_W'(1);
				end else begin
					pc_d  = '0;
					cnt_d = cnt_adv;
					if (cnt_adv == mv_q) begin
						if (mc_q[MC_INT])
							flag_d = 1'b1;
						if (mc_q[MC_STOP])
							en_d = 1'b0;
					end
				end
			end
		end else if (req.wr && hit) begin
			unique case (req.idx)
				REG_FLAG: begin
					if (req.wdata[0])
						flag_d = 1'b0;
				end
				REG_CTRL: begin
					en_d   = req.wdata[CTRL_EN];
					hold_d = req.wdata[CTRL_HOLD];
				end
				REG_COUNT:  cnt_d = wfit;
				REG_PRESC:  pv_d  = wfit;
				REG_PCOUNT: pc_d  = wfit;
				REG_MATCH:  mv_d  = wfit;
				REG_MCTRL:  mc_d  = req.wdata[MC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rdata = '0;
		if (req.rd && hit) begin
			unique case (req.idx)
				REG_FLAG:   rdata = {{(WORD_W-1){1'b0}}, flag_q};
				REG_CTRL:   rdata = {{(WORD_W-2){1'b0}}, hold_q, en_q};
				REG_COUNT:  rdata = cnt_to_word(cnt_q);
				REG_PRESC:  rdata = cnt_to_word(pv_q);
				REG_PCOUNT: rdata = cnt_to_word(pc_q);
				REG_MATCH:  rdata = cnt_to_word(mv_q);
				REG_MCTRL:  rdata = {{(WORD_W-MC_W){1'b0}}, mc_q};
				default:    rdata = '0;
			endcase
		end
	end

	assign flag_nx = flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			hold_q <= 1'b0;
			flag_q <= 1'b0;
			cnt_q  <= '0;
			pv_q   <= '0;
			pc_q   <= '0;
			mv_q   <= '0;
			mc_q   <= '0;
		end else if (req.go) begin
			en_q   <= en_d;
			hold_q <= hold_d;
			flag_q <= flag_d;
			cnt_q  <= cnt_d;
			pv_q   <= pv_d;
			pc_q   <= pc_d;
			mv_q   <= mv_d;
			mc_q   <= mc_d;
		end
	end

endmodule

FILE: src/pmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module pmt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pmt_pkg::OUT_DATA_W-1:0] m_tdata
);
	import pmt_pkg::*;

	// stalled result must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a ready receiver never backs up the request side
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("request side stalled with receiver ready");

	// every accepted request shows a result once past the input register
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##1 m_tvalid)
		else $error("result missing after request");

	// padding bits stay clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_BITS] == '0)
		else $error("padding bits set in result");

endmodule

bind prescaled_match_timer pmt_checker u_pmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/tb_prescaled_match_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prescaled_match_timer
// Self-checking bench for the two-timer match/prescale bank. A short directed
// section covers reset values, register extremes, count wrap, prescale count
// above the prescale value, match actions, reset hold and unused codes. Then
// randomized timer programs run: set up one timer, then mixed ticks, reads and
// noise. Both streams insert random gaps. Each result is compared with an
// untimed model of the timers, kept in step at request acceptance.
// ----------------------------------------------------------------------------
module tb_prescaled_match_timer;
	import pmt_pkg::*;

	localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int DIRECTED_REQUESTS = 25;
	localparam int RANDOM_REQUESTS   = 1000;
	localparam int CYCLE_LIMIT       = 400000;
	localparam int DRAIN_CYCLES      = 10;

	typedef struct {
		logic             en;
		logic             hold;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] presc;
		logic [CNT_W-1:0] pcount;
		logic [CNT_W-1:0] match;
		logic [MC_W-1:0]  mctrl;
		logic             flag;
	} timer_regs_t;

	// same bit order as m_tdata
	typedef struct packed {
		logic              irq1;
		logic              irq0;
		logic [WORD_W-1:0] rdata;
	} timer_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // write_data
	logic [IN_USER_W-1:0]  s_tuser;   // operation, timer_select, register_index
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // read_data, irq_timer0, irq_timer1, pad

	timer_regs_t   timers [TIMER_NUM];
	timer_result_t pending_results [$];
	int            error_count = 0;
	int            cycle_count = 0;
	int            sent_count  = 0;
	int            send_calm   = 0;
	int            recv_calm   = 0;

	prescaled_match_timer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Gap before the next handshake; occasionally a run of back-to-back items.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 19);
	endfunction

	// Applies one request to the timer model, returns the result it yields.
	function automatic timer_result_t timer_bank_step(input logic [OP_W-1:0] op,
		input logic sel, input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] wdata);
		timer_result_t res;
		int i;
		res.rdata = '0;
		if (op == OP_TICK) begin
			for (i = 0; i < TIMER_NUM; i++) begin
				if (timers[i].hold) begin
					timers[i].count  = '0;
					timers[i].pcount = '0;
				end else if (timers[i].en) begin
					if (timers[i].pcount != timers[i].presc) begin
						timers[i].pcount = timers[i].pcount + 1'b1;
					end else begin
						timers[i].pcount = '0;
						// match reset acts on the advance after the match
						if (timers[i].mctrl[MC_RST] && timers[i].count == timers[i].match)
							timers[i].count = '0;
						else
							timers[i].count = timers[i].count + 1'b1;
						if (timers[i].count == timers[i].match) begin
							if (timers[i].mctrl[MC_INT])
								timers[i].flag = 1'b1;
							if (timers[i].mctrl[MC_STOP])
								timers[i].en = 1'b0;
						end
					end
				end
			end
		end else if (int'(sel) < TIMER_NUM) begin
			if (op == OP_READ) begin
				case (idx)
					REG_FLAG:   res.rdata = WORD_W'(timers[sel].flag);
					REG_CTRL:   res.rdata = WORD_W'({timers[sel].hold, timers[sel].en});
					REG_COUNT:  res.rdata = WORD_W'(timers[sel].count);
					REG_PRESC:  res.rdata = WORD_W'(timers[sel].presc);
					REG_PCOUNT: res.rdata = WORD_W'(timers[sel].pcount);
					REG_MATCH:  res.rdata = WORD_W'(timers[sel].match);
					REG_MCTRL:  res.rdata = WORD_W'(timers[sel].mctrl);
					default:    res.rdata = '0;
				endcase
			end else if (op == OP_WRITE) begin
				case (idx)
					REG_FLAG: begin
						if (wdata[0])
							timers[sel].flag = 1'b0;
					end
					REG_CTRL: begin
						timers[sel].en   = wdata[CTRL_EN];
						timers[sel].hold = wdata[CTRL_HOLD];
					end
					REG_COUNT:  timers[sel].count  = CNT_W'(wdata);
					REG_PRESC:  timers[sel].presc  = CNT_W'(wdata);
					REG_PCOUNT: timers[sel].pcount = CNT_W'(wdata);
					REG_MATCH:  timers[sel].match  = CNT_W'(wdata);
					REG_MCTRL:  timers[sel].mctrl  = wdata[MC_W-1:0];
					default: ;
				endcase
			end
		end
		res.irq0 = timers[0].flag;
		res.irq1 = (TIMER_NUM > 1) ? timers[TIMER_NUM > 1 ? 1 : 0].flag : 1'b0;
		return res;
	endfunction

	task automatic send_request(input logic [OP_W-1:0] op, input logic sel,
		input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] wdata);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'(wdata);
		s_tuser  <= {idx, sel, op};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(timer_bank_step(op, sel, idx, wdata));
		sent_count++;
	endtask

	// ignored fields of a tick carry random values
	task automatic send_tick();
		send_request(OP_TICK, 1'($urandom), IDX_W'($urandom), $urandom);
	endtask

	initial begin : result_checker
		int gap;
		timer_result_t got;
		timer_result_t want;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata[OUT_BITS-1:0];
			if (pending_results.size() == 0) begin
				$error("result with no request pending: %h", got);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.rdata !== want.rdata) begin
					$error("read_data: expected %h, got %h", want.rdata, got.rdata);
					error_count++;
				end
				if (got.irq0 !== want.irq0) begin
					$error("irq_timer0: expected %b, got %b", want.irq0, got.irq0);
					error_count++;
				end
				if (got.irq1 !== want.irq1) begin
					$error("irq_timer1: expected %b, got %b", want.irq1, got.irq1);
					error_count++;
				end
			end
		end
	end

	task automatic test_reset_values();
		send_request(OP_READ, 1'b0, REG_MCTRL, $urandom);
	endtask

	task automatic test_register_extremes();
		send_request(OP_WRITE, 1'b1, REG_MATCH, 32'hFFFF_FFFF);
		send_request(OP_READ, 1'b1, REG_MATCH, 32'h0);
		send_request(OP_WRITE, 1'b1, REG_MATCH, 32'h0);
		send_request(OP_READ, 1'b1, REG_MATCH, 32'hFFFF_FFFF);
	endtask

	task automatic test_wrap_and_prescale();
		send_request(OP_WRITE, 1'b0, REG_COUNT, 32'hFFFF_FFFF);
		send_request(OP_WRITE, 1'b0, REG_CTRL, 32'h1 << CTRL_EN);
		send_tick();
		send_request(OP_READ, 1'b0, REG_COUNT, 32'h0);
		// prescale count past the prescale value keeps counting
		send_request(OP_WRITE, 1'b0, REG_PRESC, 32'd1);
		send_request(OP_WRITE, 1'b0, REG_PCOUNT, 32'd5);
		send_tick();
		send_request(OP_READ, 1'b0, REG_PCOUNT, 32'h0);
	endtask

	task automatic test_match_actions();
		send_request(OP_WRITE, 1'b1, REG_MCTRL, 32'h7);
		send_request(OP_WRITE, 1'b1, REG_MATCH, 32'd1);
		send_request(OP_WRITE, 1'b1, REG_CTRL, 32'h1 << CTRL_EN);
		send_tick();
		send_request(OP_READ, 1'b1, REG_CTRL, 32'h0);
		send_request(OP_WRITE, 1'b1, REG_FLAG, 32'h1);
	endtask

	task automatic test_reset_hold();
		send_request(OP_WRITE, 1'b0, REG_CTRL, (32'h1 << CTRL_EN) | (32'h1 << CTRL_HOLD));
		send_tick();
		send_request(OP_READ, 1'b0, REG_PCOUNT, 32'h0);
	endtask

	task automatic test_unused_codes();
		send_request(OP_UNUSED, 1'($urandom), IDX_W'($urandom), $urandom);
		send_request(OP_WRITE, 1'b0, REG_UNUSED, $urandom);
		send_request(OP_READ, 1'b1, REG_UNUSED, $urandom);
	endtask

	// Program one timer, then run mixed ticks, reads and noise.
	task automatic run_timer_program();
		logic             sel;
		logic [CNT_W-1:0] start;
		logic [CNT_W-1:0] target;
		int               steps;
		int               pick;
		sel = 1'($urandom);
		case ($urandom_range(0, 3))
			0:       start = '0;
			1:       start = CNT_W'($urandom_range(0, 10));
			2:       start = '1 - CNT_W'($urandom_range(0, 5));
			default: start = CNT_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0, 1:    target = CNT_W'($urandom_range(0, 12));
			2:       target = start + CNT_W'($urandom_range(0, 6));
			default: target = CNT_W'($urandom);
		endcase
		send_request(OP_WRITE, sel, REG_CTRL, $urandom & ~32'h3);
		send_request(OP_WRITE, sel, REG_PRESC, $urandom_range(0, 3));
		send_request(OP_WRITE, sel, REG_COUNT, WORD_W'(start));
		send_request(OP_WRITE, sel, REG_MATCH, WORD_W'(target));
		send_request(OP_WRITE, sel, REG_PCOUNT, $urandom_range(0, 1));
		send_request(OP_WRITE, sel, REG_MCTRL, $urandom);
		send_request(OP_WRITE, sel, REG_FLAG, $urandom);
		send_request(OP_WRITE, sel, REG_CTRL, ($urandom & ~32'h3) | (32'h1 << CTRL_EN));
		steps = $urandom_range(8, 48);
		repeat (steps) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				send_tick();
			else if (pick < 88)
				send_request(OP_READ, 1'($urandom), IDX_W'($urandom_range(0, 7)), $urandom);
			else if (pick < 93)
				send_request(OP_WRITE, 1'($urandom), REG_FLAG, $urandom);
			else if (pick < 96)
				send_request(OP_WRITE, sel, REG_CTRL, $urandom);
			else
				send_request(OP_W'($urandom), 1'($urandom), IDX_W'($urandom), $urandom);
		end
	endtask

	task automatic test_random_traffic();
		while (sent_count < DIRECTED_REQUESTS + RANDOM_REQUESTS)
			run_timer_program();
	endtask

	initial begin
		int i;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		for (i = 0; i < TIMER_NUM; i++)
			timers[i] = '{default: '0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_extremes();
		test_wrap_and_prescale();
		test_match_actions();
		test_reset_hold();
		test_unused_codes();
		test_random_traffic();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
